@@ rtl/positional_list_engine_unit_macros.svh @@
// Assertion macros for the positional list engine.
// Depends on: ports clk and rst_n being visible where a macro is used.
`ifndef POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PLE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define PLE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ple_pkg.sv @@
// Shared types and constants of the positional list engine.
// Depends on: nothing.
package ple_pkg;

  localparam int CMD_W  = 3;
  localparam int VAL_W  = 32;
  localparam int POS_W  = 5;
  localparam int STAT_W = 2;
  localparam int OCNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_FRONT = 3'd0,
    CMD_INS_BACK  = 3'd1,
    CMD_INS_AT    = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_DEL_BACK  = 3'd4,
    CMD_DEL_AT    = 3'd5,
    CMD_DUMP      = 3'd6
  } cmd_e_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } stat_e_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic setup;
    logic shift_step;
    logic finish;
    logic dump_read;
    logic dump_emit;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic dump_go;
    logic shift_done;
    logic out_free;
    logic dump_last;
  } dp_stat_t;

endpackage

@@ rtl/ple_ctrl.sv @@
// Command sequencer of the positional list engine.
// Depends on: ple_pkg (dp_cmd_t, dp_stat_t).
module ple_ctrl import ple_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    S_IDLE      = 6'b000001,
    S_DECODE    = 6'b000010,
    S_SHIFT     = 6'b000100,
    S_FINISH    = 6'b001000,
    S_DUMP_RD   = 6'b010000,
    S_DUMP_EMIT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.setup = 1'b1;
        state_nxt = stat.dump_go ? S_DUMP_RD : S_SHIFT;
      end
      S_SHIFT: begin
        if (stat.shift_done) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd.dump_read = 1'b1;
        state_nxt     = S_DUMP_EMIT;
      end
      S_DUMP_EMIT: begin
        if (stat.out_free) begin
          cmd.dump_emit = 1'b1;
          if (stat.dump_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ple_datapath.sv @@
// Datapath of the positional list engine: element memory, count, walk
// pointer and result register. Depends on: ple_pkg.
module ple_datapath import ple_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic        [CMD_W-1:0] in_command,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic        [POS_W-1:0] in_position,
  input  dp_cmd_t                 cmd,
  output dp_stat_t                stat,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic       [STAT_W-1:0] out_status,
  output logic       [OCNT_W-1:0] out_element_count,
  output logic signed [VAL_W-1:0] out_element_value,
  output logic        [POS_W-1:0] out_element_position,
  output logic                    out_last_result
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = ((CW > POS_W) ? CW : POS_W) + 2;

  // captured item
  cmd_e_t                 cmd_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic [POS_W-1:0]       pos_r;

  // list state and walk
  logic [CW-1:0]          count_r;
  logic [AW-1:0]          idx_r;
  logic [AW-1:0]          wa_r;
  logic [AW-1:0]          tgt_r;
  logic [CW-1:0]          rem_r;
  logic                   wb_r;
  logic                   op_ins_r;
  logic                   op_del_r;
  stat_e_t                status_r;

  // memory
  logic [VALUE_WIDTH-1:0] mem [CAPACITY];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   mem_we;
  logic                   mem_re;
  logic [AW-1:0]          mem_wa;
  logic [AW-1:0]          mem_ra;
  logic [VALUE_WIDTH-1:0] mem_wd;

  // result register
  logic                   res_valid_r;
  stat_e_t                res_status_r;
  logic [OCNT_W-1:0]      res_count_r;
  logic [VAL_W-1:0]       res_value_r;
  logic [POS_W-1:0]       res_pos_r;
  logic                   res_last_r;

  // decode
  logic [EW-1:0]          cnt_e;
  logic [EW-1:0]          pos_e;
  logic [EW-1:0]          tgt_e;
  logic [EW-1:0]          emit_pos_e;
  logic                   full;
  logic                   empty;
  logic                   dec_ins;
  logic                   dec_del;
  stat_e_t                dec_status;
  logic [CW-1:0]          cnt_after;

  assign cnt_e      = EW'(count_r);
  assign pos_e      = EW'(pos_r);
  assign emit_pos_e = EW'(idx_r) + EW'(1);
  assign full       = (count_r == CW'(CAPACITY));
  assign empty      = (count_r == '0);

  always_comb begin
    dec_status = ST_OK;
    dec_ins    = 1'b0;
    dec_del    = 1'b0;
    tgt_e      = '0;
    unique case (cmd_r)
      CMD_INS_FRONT: begin
        if (full) dec_status = ST_FULL;
        else dec_ins = 1'b1;
      end
      CMD_INS_BACK: begin
        tgt_e = cnt_e;
        if (full) dec_status = ST_FULL;
        else dec_ins = 1'b1;
      end
      CMD_INS_AT: begin
        tgt_e = pos_e - EW'(1);
        priority if (pos_e == '0 || pos_e > cnt_e + EW'(1)) dec_status = ST_BADPOS;
        else if (full) dec_status = ST_FULL;
        else dec_ins = 1'b1;
      end
      CMD_DEL_FRONT: begin
        if (empty) dec_status = ST_EMPTY;
        else dec_del = 1'b1;
      end
      CMD_DEL_BACK: begin
        tgt_e = cnt_e - EW'(1);
        if (empty) dec_status = ST_EMPTY;
        else dec_del = 1'b1;
      end
      CMD_DEL_AT: begin
        tgt_e = pos_e - EW'(1);
        priority if (empty) dec_status = ST_EMPTY;
        else if (pos_e == '0 || pos_e > cnt_e) dec_status = ST_BADPOS;
        else dec_del = 1'b1;
      end
      CMD_DUMP: begin
        if (empty) dec_status = ST_EMPTY;
      end
      default: begin
        dec_status = ST_BADPOS;
      end
    endcase
  end

  assign stat.dump_go    = (cmd_r == CMD_DUMP) && !empty;
  assign stat.shift_done = (rem_r == '0) && !wb_r;
  assign stat.out_free   = !res_valid_r || out_ready;
  assign stat.dump_last  = (emit_pos_e == cnt_e);

  assign cnt_after = op_ins_r ? count_r + CW'(1) :
                     op_del_r ? count_r - CW'(1) : count_r;

  // capture and walk setup
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= cmd_e_t'(in_command);
      value_r <= VALUE_WIDTH'(in_value);
      pos_r   <= in_position;
    end
    if (cmd.setup) begin
      op_ins_r <= dec_ins;
      op_del_r <= dec_del;
      status_r <= dec_status;
      tgt_r    <= AW'(tgt_e);
    end
    if (cmd.setup) begin
      if (dec_ins) begin
        idx_r <= AW'(cnt_e - EW'(1));
        rem_r <= CW'(cnt_e - tgt_e);
      end else if (dec_del) begin
        idx_r <= AW'(tgt_e + EW'(1));
        rem_r <= CW'(cnt_e - tgt_e - EW'(1));
      end else begin
        idx_r <= '0;
        rem_r <= '0;
      end
    end else if (cmd.shift_step && rem_r != '0) begin
      wa_r  <= op_ins_r ? idx_r + AW'(1) : idx_r - AW'(1);
      idx_r <= op_ins_r ? idx_r - AW'(1) : idx_r + AW'(1);
      rem_r <= rem_r - CW'(1);
    end else if (cmd.dump_emit) begin
      idx_r <= idx_r + AW'(1);
    end
  end

  // pending shift write and element count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_r    <= 1'b0;
      count_r <= '0;
    end else begin
      if (cmd.shift_step) wb_r <= (rem_r != '0);
      if (cmd.finish) count_r <= cnt_after;
    end
  end

  always_comb begin
    mem_we = 1'b0;
    mem_wa = wa_r;
    mem_wd = rd_data_r;
    mem_re = 1'b0;
    mem_ra = idx_r;
    if (cmd.shift_step) begin
      mem_we = wb_r;
      mem_re = (rem_r != '0);
    end
    if (cmd.finish && op_ins_r) begin
      mem_we = 1'b1;
      mem_wa = tgt_r;
      mem_wd = value_r;
    end
    if (cmd.dump_read) mem_re = 1'b1;
    if (cmd.dump_emit) begin
      mem_re = 1'b1;
      mem_ra = idx_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data_r <= mem[mem_ra];
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_valid_r <= 1'b0;
    end else if (cmd.finish || cmd.dump_emit) begin
      res_valid_r <= 1'b1;
    end else if (out_ready) begin
      res_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      res_status_r <= status_r;
      res_count_r  <= OCNT_W'(cnt_after);
      res_value_r  <= '0;
      res_pos_r    <= '0;
      res_last_r   <= 1'b1;
    end else if (cmd.dump_emit) begin
      res_status_r <= ST_OK;
      res_count_r  <= OCNT_W'(count_r);
      res_value_r  <= VAL_W'(rd_data_r);
      res_pos_r    <= POS_W'(emit_pos_e);
      res_last_r   <= stat.dump_last;
    end
  end

  assign out_valid            = res_valid_r;
  assign out_status           = res_status_r;
  assign out_element_count    = res_count_r;
  assign out_element_value    = res_value_r;
  assign out_element_position = res_pos_r;
  assign out_last_result      = res_last_r;

endmodule

@@ rtl/positional_list_engine_unit.sv @@
// Top level of the positional list engine: sequencer plus datapath.
// Depends on: ple_pkg, ple_ctrl, ple_datapath, positional_list_engine_unit_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-------------------------------------
//   in_     | input     | in_valid / in_ready   | command, value, position
//   out_    | output    | out_valid / out_ready | status, element_count, element_value,
//           |           |                      | element_position, last_result
//
// Items: one item at a time. An insert or delete that moves entries is paced by the
//   single-write-port element memory moving one entry a cycle. Dump gives one result
//   per cycle while the receiver holds out_ready high.
// Reset: synchronous active-low rst_n clears the count and the control state; the
//   element memory is not cleared and needs no sweep.
// Stalls: a held result blocks only the next result; a new item is taken while a
//   result waits in the output register.
`include "positional_list_engine_unit_macros.svh"

module positional_list_engine_unit import ple_pkg::*; #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic        [CMD_W-1:0]  in_command,
  input  logic signed [VAL_W-1:0]  in_value,
  input  logic        [POS_W-1:0]  in_position,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic        [STAT_W-1:0] out_status,
  output logic        [OCNT_W-1:0] out_element_count,
  output logic signed [VAL_W-1:0]  out_element_value,
  output logic        [POS_W-1:0]  out_element_position,
  output logic                     out_last_result
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // Sequencer: walks each item through decode, then either shift and finish or a dump.
  ple_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // Datapath: element memory, count, walk pointer and the result register.
  ple_datapath #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_command           (in_command),
    .in_value             (in_value),
    .in_position          (in_position),
    .cmd                  (dp_cmd),
    .stat                 (dp_stat),
    .out_ready            (out_ready),
    .out_valid            (out_valid),
    .out_status           (out_status),
    .out_element_count    (out_element_count),
    .out_element_value    (out_element_value),
    .out_element_position (out_element_position),
    .out_last_result      (out_last_result)
  );

  // The sequencer issues at most one datapath command per cycle.
  `PLE_ASSERT_SAME(a_one_cmd, 1'b1, $onehot0(dp_cmd), "more than one datapath command")

  // An accepted item blocks the input until its work is done.
  `PLE_ASSERT_NEXT(a_hold_input, in_valid && in_ready, !in_ready, "input taken twice in a row")

  // Only a dump element may come without the last mark, and it is always ok.
  `PLE_ASSERT_SAME(a_dump_ok, out_valid && !out_last_result, out_status == ST_OK,
                   "non-final result with bad status")

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine_unit: a directed command table, then
// random fill and drain sweeps under three idle patterns. Depends on ple_pkg and the unit.
module tb;
  import ple_pkg::*;

  localparam int CAPACITY       = 16;
  localparam int VALUE_WIDTH    = 32;
  localparam int ITEMS_PER_PASS = 130;
  localparam int TAIL_CYCLES    = 2 * (CAPACITY + 8);
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 40;
  // Command code with no operation behind it; the unit answers it with a bad-position status.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

  // One result as it leaves the out_ channel.
  typedef struct {
    stat_e_t                 status;
    logic [OCNT_W-1:0]       count;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic                    last;
  } list_result_t;

  // One directed row; rows with has_fixed carry a single hand-written non-dump result.
  typedef struct {
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    bit                      has_fixed;
    stat_e_t                 status;
    logic [OCNT_W-1:0]       count;
  } command_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic        [CMD_W-1:0]  in_command = '0;
  logic signed [VAL_W-1:0]  in_value = '0;
  logic        [POS_W-1:0]  in_position = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic        [STAT_W-1:0] out_status;
  logic        [OCNT_W-1:0] out_element_count;
  logic signed [VAL_W-1:0]  out_element_value;
  logic        [POS_W-1:0]  out_element_position;
  logic                     out_last_result;

  // Shadow copy of the list, front at index 0, and the results still owed by the unit.
  logic signed [VAL_W-1:0] held_values[$];
  list_result_t            owed_results[$];

  int sender_idle_pct   = 30;
  int receiver_idle_pct = 75;
  int mismatch_count    = 0;
  int quiet_cycles      = 0;
  bit filling           = 1'b1;

  // Directed part: empty-list corners first, then value extremes and position bounds.
  command_row_t directed_rows [21] = '{
    '{CMD_DUMP,      '0,            5'd0,  1'b1, ST_EMPTY,  5'd0},
    '{CMD_DEL_FRONT, '0,            5'd0,  1'b1, ST_EMPTY,  5'd0},
    '{CMD_DEL_BACK,  '0,            5'd0,  1'b1, ST_EMPTY,  5'd0},
    '{CMD_DEL_AT,    '0,            5'd1,  1'b1, ST_EMPTY,  5'd0},
    '{CMD_INS_AT,    32'sd5,        5'd0,  1'b1, ST_BADPOS, 5'd0},
    '{CMD_INS_AT,    32'sd5,        5'd2,  1'b1, ST_BADPOS, 5'd0},
    '{CMD_UNUSED,    '0,            5'd31, 1'b1, ST_BADPOS, 5'd0},
    '{CMD_INS_FRONT, 32'sh7FFFFFFF, 5'd0,  1'b1, ST_OK,     5'd1},
    '{CMD_INS_BACK,  32'sh80000000, 5'd31, 1'b1, ST_OK,     5'd2},
    '{CMD_INS_AT,    '0,            5'd3,  1'b1, ST_OK,     5'd3},
    '{CMD_INS_AT,    32'shFFFFFFFF, 5'd1,  1'b1, ST_OK,     5'd4},
    '{CMD_DUMP,      '0,            5'd0,  1'b0, ST_OK,     5'd0},
    '{CMD_DEL_AT,    '0,            5'd0,  1'b1, ST_BADPOS, 5'd4},
    '{CMD_DEL_AT,    '0,            5'd5,  1'b1, ST_BADPOS, 5'd4},
    '{CMD_DEL_AT,    '0,            5'd31, 1'b1, ST_BADPOS, 5'd4},
    '{CMD_DEL_AT,    '0,            5'd2,  1'b1, ST_OK,     5'd3},
    '{CMD_DEL_FRONT, '0,            5'd0,  1'b1, ST_OK,     5'd2},
    '{CMD_DEL_BACK,  '0,            5'd0,  1'b1, ST_OK,     5'd1},
    '{CMD_DUMP,      '0,            5'd0,  1'b0, ST_OK,     5'd0},
    '{CMD_INS_AT,    32'sh12345678, 5'd2,  1'b0, ST_OK,     5'd0},
    '{CMD_DUMP,      '0,            5'd0,  1'b0, ST_OK,     5'd0}
  };

  positional_list_engine_unit #(
    .CAPACITY    (CAPACITY),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_command           (in_command),
    .in_value             (in_value),
    .in_position          (in_position),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_element_count    (out_element_count),
    .out_element_value    (out_element_value),
    .out_element_position (out_element_position),
    .out_last_result      (out_last_result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Apply one command to the shadow list and return the results it must produce.
  function automatic void predict_list_results(input logic [CMD_W-1:0] cmd,
                                               input logic signed [VAL_W-1:0] value,
                                               input logic [POS_W-1:0] pos,
                                               output list_result_t produced[$]);
    int      count;
    stat_e_t status;
    count    = held_values.size();
    status   = ST_OK;
    produced = {};
    case (cmd)
      CMD_INS_FRONT, CMD_INS_BACK: begin
        if (count >= CAPACITY) status = ST_FULL;
        else if (cmd == CMD_INS_FRONT) held_values.push_front(value);
        else held_values.push_back(value);
      end
      CMD_INS_AT: begin
        // Position is judged before fullness.
        if (int'(pos) < 1 || int'(pos) > count + 1) status = ST_BADPOS;
        else if (count >= CAPACITY) status = ST_FULL;
        else held_values.insert(int'(pos) - 1, value);
      end
      CMD_DEL_FRONT, CMD_DEL_BACK: begin
        if (count == 0) status = ST_EMPTY;
        else if (cmd == CMD_DEL_FRONT) void'(held_values.pop_front());
        else void'(held_values.pop_back());
      end
      CMD_DEL_AT: begin
        if (count == 0) status = ST_EMPTY;
        else if (int'(pos) < 1 || int'(pos) > count) status = ST_BADPOS;
        else held_values.delete(int'(pos) - 1);
      end
      CMD_DUMP: begin
        if (count == 0) status = ST_EMPTY;
        else begin
          for (int i = 0; i < count; i++)
            produced.push_back('{ST_OK, OCNT_W'(count), held_values[i], POS_W'(i + 1),
                                 i == count - 1});
          return;
        end
      end
      default: status = ST_BADPOS;
    endcase
    produced.push_back('{status, OCNT_W'(held_values.size()), '0, '0, 1'b1});
  endfunction

  function automatic logic signed [VAL_W-1:0] random_value();
    case ($urandom_range(19))
      0:       return {1'b0, {(VAL_W - 1){1'b1}}};
      1:       return {1'b1, {(VAL_W - 1){1'b0}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a legal position in 1..top, otherwise anything the field can hold.
  function automatic logic [POS_W-1:0] random_position(int top);
    if (top >= 1 && $urandom_range(99) < 85) return POS_W'($urandom_range(top, 1));
    return POS_W'($urandom_range((1 << POS_W) - 1));
  endfunction

  // Sweep the list up to full and back down to empty, probing each boundary for a while
  // before turning; a few dumps and unused codes are mixed in.
  task automatic pick_random_command(output logic [CMD_W-1:0] cmd,
                                     output logic signed [VAL_W-1:0] value,
                                     output logic [POS_W-1:0] pos);
    int count;
    int roll;
    int kind;
    bit grow;
    count = held_values.size();
    roll  = $urandom_range(99);
    kind  = $urandom_range(3);
    value = random_value();
    grow  = filling;
    if ((filling && count == CAPACITY) || (!filling && count == 0)) begin
      if ($urandom_range(2) == 0) filling = !filling;
    end else if (roll >= 95) begin
      kind = 4;
    end else if (roll >= 88) begin
      kind = 3;
    end else begin
      kind = $urandom_range(2);
      grow = (roll < 75) ? filling : !filling;
    end
    case (kind)
      0:       cmd = grow ? CMD_INS_FRONT : CMD_DEL_FRONT;
      1:       cmd = grow ? CMD_INS_BACK : CMD_DEL_BACK;
      2:       cmd = grow ? CMD_INS_AT : CMD_DEL_AT;
      3:       cmd = CMD_DUMP;
      default: cmd = CMD_UNUSED;
    endcase
    pos = random_position(grow ? count + 1 : count);
  endtask

  // Present one item, hold it until taken, then book its results.
  task automatic issue_command(input logic [CMD_W-1:0] cmd,
                               input logic signed [VAL_W-1:0] value,
                               input logic [POS_W-1:0] pos,
                               input bit has_fixed,
                               input list_result_t fixed_result);
    list_result_t produced[$];
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_command  <= cmd;
    in_value    <= value;
    in_position <= pos;
    do @(posedge clk); while (!in_ready);
    predict_list_results(cmd, value, pos, produced);
    if (has_fixed) owed_results.push_back(fixed_result);
    else owed_results = {owed_results, produced};
  endtask

  // Drop valid and hold off until every owed result has come back.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, longint want, longint got);
    if (mismatch_count < MAX_REPORTS)
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    mismatch_count++;
  endtask

  // Receiver: stall at random per cycle at the current rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= receiver_idle_pct);
  end

  // Compare every taken result with the oldest one owed.
  always @(posedge clk) begin : result_check
    list_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        report_mismatch("result with nothing owed, status", -1, out_status);
      end else begin
        want = owed_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", want.status, out_status);
        if (out_element_count !== want.count)
          report_mismatch("element_count", want.count, out_element_count);
        if (out_element_value !== want.value)
          report_mismatch("element_value", want.value, out_element_value);
        if (out_element_position !== want.position)
          report_mismatch("element_position", want.position, out_element_position);
        if (out_last_result !== want.last)
          report_mismatch("last_result", want.last, out_last_result);
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves an item.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [CMD_W-1:0]        cmd;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        pos;
    list_result_t            fixed;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; fixed rows are checked against their typed-in result.
    foreach (directed_rows[r]) begin
      fixed = '{directed_rows[r].status, directed_rows[r].count, '0, '0, 1'b1};
      issue_command(directed_rows[r].cmd, directed_rows[r].value, directed_rows[r].pos,
                    directed_rows[r].has_fixed, fixed);
    end

    // Three passes: sender-light/receiver-heavy idling, the reverse, then none at all.
    for (int pass = 0; pass < 3; pass++) begin
      sender_idle_pct   = (pass == 0) ? 30 : (pass == 1) ? 75 : 0;
      receiver_idle_pct = (pass == 0) ? 75 : (pass == 1) ? 30 : 0;
      hold_until_drained();
      repeat (ITEMS_PER_PASS) begin
        pick_random_command(cmd, value, pos);
        issue_command(cmd, value, pos, 1'b0, fixed);
        if ($urandom_range(99) < 3) hold_until_drained();
      end
    end

    // Drain, then give the unit time to show any stray result.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
